// ----- hw/rtl/edb_pkg.sv -----
// Shared types and constants of the emulated data bus decoder.
`default_nettype none

package edb_pkg;

  localparam int unsigned AddrBits        = 24;
  localparam int unsigned DataBits        = 8;
  localparam int unsigned MaskBits        = 4;
  localparam int unsigned HitsBits        = 32;
  localparam int unsigned CodeAddrBitsDef = 20;
  localparam int unsigned RamOffsetDef    = 36864;
  localparam int unsigned RamDepth        = 24576;
  localparam int unsigned RamAddrBits     = $clog2(RamDepth);

  localparam logic [MaskBits-1:0] MirrorMaskReset = 4'hF;
  localparam logic [15:0]         SegLowMask      = 16'hFFFF;
  localparam logic [AddrBits-1:0] RamBase         = 24'h009000;
  localparam logic [AddrBits-1:0] SfrBase         = 24'h00F000;
  localparam logic [AddrBits-1:0] SegBase         = 24'h010000;
  localparam logic [AddrBits-1:0] CodeEnd         = 24'h100000;

  typedef enum logic [1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActLoad  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StUnmapped  = 3'd1,
    StReadOnly  = 3'd2,
    StRomWindow = 3'd3,
    StSfr       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SrcZero = 2'd0,
    SrcCode = 2'd1,
    SrcRam  = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [AddrBits-1:0] address;
    logic [DataBits-1:0] data;
  } in_t;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic [2:0]          status;
    logic [HitsBits-1:0] window_hits;
  } out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/emulated_data_bus_decoder.sv -----
// Top level of the emulated data bus decoder with its code and data memories.
// A transfer passes the memory stage register and then the output register before its result is valid.
// Throughput: one transfer per cycle unless out_ready_i stalls; the registered memory read sets the latency.
// Reset clears the ROM window counter and the pipeline valid flags and sets the mirror mask to 15.
// The code and data memories are not cleared and hold unknown data until written.
`default_nettype none

module emulated_data_bus_decoder #(
  parameter int unsigned CodeAddrBits = edb_pkg::CodeAddrBitsDef,
  parameter int unsigned RamOffset    = edb_pkg::RamOffsetDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire edb_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output edb_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [edb_pkg::MaskBits-1:0]  cfg_wdata_i
);

  import edb_pkg::*;

  typedef struct packed {
    status_e             status;
    rd_src_e             src;
    logic [HitsBits-1:0] hits;
  } stage_t;

  logic [MaskBits-1:0] mirror_q;
  logic [HitsBits-1:0] win_q, win_d;
  logic                s1_valid_q, s1_valid_d;
  stage_t              s1_q, s1_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                in_fire, adv_out;
  logic [1:0]          act;
  logic [AddrBits-1:0] addr;
  logic [AddrBits-1:0] ram_idx, code_mask, code_mirr;
  logic                in_ram, in_sfr, in_rom, in_seg, ram_ok, wr;
  logic                win_inc, code_acc, code_we, ram_acc, ram_we;
  logic [CodeAddrBits-1:0] code_addr;
  logic [DataBits-1:0] code_rdata, ram_rdata;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv_out;
  assign in_fire    = in_valid_i && in_ready_o;

  assign act       = in_data_i.action;
  assign addr      = in_data_i.address;
  assign wr        = (act == ActWrite);
  assign in_ram    = (addr >= RamBase) && (addr < SfrBase);
  assign in_sfr    = (addr >= SfrBase) && (addr < SegBase);
  assign in_rom    = (addr < RamBase);
  assign in_seg    = (addr < CodeEnd);
  assign ram_idx   = addr - AddrBits'(RamOffset);
  assign ram_ok    = (ram_idx < AddrBits'(RamDepth));
  assign code_mask = {4'b0000, mirror_q, SegLowMask};
  assign code_mirr = addr & code_mask;

  always_comb begin
    s1_d.status = StOk;
    s1_d.src    = SrcZero;
    win_inc     = 1'b0;
    code_acc    = 1'b0;
    code_we     = 1'b0;
    ram_acc     = 1'b0;
    ram_we      = 1'b0;
    code_addr   = code_mirr[CodeAddrBits-1:0];
    unique case (act) inside
      ActLoad: begin
        code_acc  = 1'b1;
        code_we   = 1'b1;
        code_addr = addr[CodeAddrBits-1:0];
      end
      ActRead, ActWrite: begin
        if (in_ram) begin
          if (ram_ok) begin
            ram_acc  = 1'b1;
            ram_we   = wr;
            s1_d.src = wr ? SrcZero : SrcRam;
          end
        end else if (in_sfr) begin
          s1_d.status = StSfr;
        end else if (in_rom) begin
          win_inc = 1'b1;
          if (wr) begin
            s1_d.status = StReadOnly;
          end else begin
            s1_d.status = StRomWindow;
            s1_d.src    = SrcCode;
            code_acc    = 1'b1;
          end
        end else if (in_seg) begin
          if (wr) begin
            s1_d.status = StReadOnly;
          end else begin
            s1_d.src = SrcCode;
            code_acc = 1'b1;
          end
        end else begin
          s1_d.status = StUnmapped;
        end
      end
      default: begin
      end
    endcase
    win_d     = win_q + HitsBits'(win_inc);
    s1_d.hits = win_d;
  end

  edb_ram #(
    .Width(DataBits),
    .Depth(2 ** CodeAddrBits)
  ) u_code_ram (
    .clk_i  (clk_i),
    .en_i   (in_fire && code_acc),
    .we_i   (code_we),
    .addr_i (code_addr),
    .wdata_i(in_data_i.data),
    .rdata_o(code_rdata)
  );

  edb_ram #(
    .Width(DataBits),
    .Depth(RamDepth)
  ) u_data_ram (
    .clk_i  (clk_i),
    .en_i   (in_fire && ram_acc),
    .we_i   (ram_we),
    .addr_i (ram_idx[RamAddrBits-1:0]),
    .wdata_i(in_data_i.data),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
    out_valid_d = adv_out ? s1_valid_q : out_valid_q;
    out_d       = out_q;
    if (s1_valid_q && adv_out) begin
      out_d.status      = s1_q.status;
      out_d.window_hits = s1_q.hits;
      case (s1_q.src)
        SrcCode: out_d.read_data = code_rdata;
        SrcRam:  out_d.read_data = ram_rdata;
        default: out_d.read_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q    <= MirrorMaskReset;
      win_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mirror_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        win_q <= win_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_win_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && win_inc) |=> $stable(win_q))
    else $error("ROM window counter changed without a window transfer.");

  a_load_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act == ActLoad) |=> (s1_q.status == StOk && s1_q.src == SrcZero))
    else $error("Code load did not produce an ok status with zero data.");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StUnmapped || out_data_o.status == StSfr ||
     out_data_o.status == StReadOnly)) |-> (out_data_o.read_data == '0))
    else $error("Faulting transfer returned nonzero read data.");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && adv_out) |=> out_valid_q)
    else $error("Result was lost between the memory stage and the output register.");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/edb_ram.sv -----
// Generic single-port RAM with a registered read port.
`default_nettype none

module edb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] addr_i,
  input  wire logic [Width-1:0]    wdata_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
